### rtl/core/normal_vector_quantizer_macros.svh
// Assertion macros shared by the normal vector quantizer.
`ifndef NORMAL_VECTOR_QUANTIZER_MACROS_SVH
`define NORMAL_VECTOR_QUANTIZER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NVQ_ASSERT_NOW(label, clk, rst, cond, expect_cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_cond)) \
    else $error("normal_vector_quantizer: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define NVQ_ASSERT_NEXT(label, clk, rst, cond, expect_cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_cond)) \
    else $error("normal_vector_quantizer: next-cycle check failed");

`endif

### rtl/core/nvq_pkg.sv
package nvq_pkg;

  // Control bits that travel with each transaction down the chain.
  typedef struct packed {
    logic valid;
    logic flip;
    logic is_null;
  } nvq_ctl_t;

  // Sub-triangle picked at one subdivision level.
  typedef enum logic [1:0] {
    SEC_X      = 2'd0,
    SEC_Y      = 2'd1,
    SEC_Z      = 2'd2,
    SEC_CORNER = 2'd3
  } nvq_sector_t;

  // Number of vector components.
  localparam int unsigned NUM_COMP = 3;

  // Width of the octant field at the bottom of a fresh code.
  localparam int unsigned OCT_BITS = 3;

endpackage

### rtl/core/nvq_front.sv
module nvq_front #(
  parameter int unsigned LEVELS  = 9,
  parameter int unsigned IN_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [IN_BITS-1:0]     comp_x,
  input  logic signed [IN_BITS-1:0]     comp_y,
  input  logic signed [IN_BITS-1:0]     comp_z,
  output nvq_pkg::nvq_ctl_t             ctl_out,
  output logic [IN_BITS-1:0]            mag_out [nvq_pkg::NUM_COMP],
  output logic [IN_BITS+LEVELS:0]       lo_out  [nvq_pkg::NUM_COMP],
  output logic [IN_BITS+LEVELS:0]       hi_out  [nvq_pkg::NUM_COMP],
  output logic [2*LEVELS+3:0]           code_out
);

  localparam int unsigned NW        = IN_BITS + 1;
  localparam int unsigned SW        = IN_BITS + LEVELS + 1;
  localparam int unsigned CODE_BITS = 2 * LEVELS + 4;

  logic [IN_BITS-1:0] mag [nvq_pkg::NUM_COMP];
  logic [NW-1:0]      norm;
  logic [SW-1:0]      norm_scaled;

  // Magnitudes of the components; the most negative value maps to 2^(IN_BITS-1).
  assign mag[0] = comp_x[IN_BITS-1] ? (~comp_x + 1'b1) : comp_x;
  assign mag[1] = comp_y[IN_BITS-1] ? (~comp_y + 1'b1) : comp_y;
  assign mag[2] = comp_z[IN_BITS-1] ? (~comp_z + 1'b1) : comp_z;

  // L1 norm, and the box top scaled by the norm so later compares need no divide.
  assign norm        = NW'(mag[0]) + NW'(mag[1]) + NW'(mag[2]);
  assign norm_scaled = SW'({norm, {LEVELS{1'b0}}});

  // Control register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out.valid   <= in_valid;
      ctl_out.flip    <= 1'b0;
      ctl_out.is_null <= (norm == '0);
    end
  end

  // Payload registers: magnitudes, initial box and octant bits.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < nvq_pkg::NUM_COMP; i++) begin
        mag_out[i] <= mag[i];
        lo_out[i]  <= '0;
        hi_out[i]  <= norm_scaled;
      end
      code_out <= CODE_BITS'({comp_x[IN_BITS-1], comp_y[IN_BITS-1], comp_z[IN_BITS-1]});
    end
  end

endmodule

### rtl/core/nvq_cell.sv
module nvq_cell #(
  parameter int unsigned LEVELS  = 9,
  parameter int unsigned IN_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  nvq_pkg::nvq_ctl_t       ctl_in,
  input  logic [IN_BITS-1:0]      mag_in  [nvq_pkg::NUM_COMP],
  input  logic [IN_BITS+LEVELS:0] lo_in   [nvq_pkg::NUM_COMP],
  input  logic [IN_BITS+LEVELS:0] hi_in   [nvq_pkg::NUM_COMP],
  input  logic [2*LEVELS+3:0]     code_in,
  output nvq_pkg::nvq_ctl_t       ctl_out,
  output logic [IN_BITS-1:0]      mag_out [nvq_pkg::NUM_COMP],
  output logic [IN_BITS+LEVELS:0] lo_out  [nvq_pkg::NUM_COMP],
  output logic [IN_BITS+LEVELS:0] hi_out  [nvq_pkg::NUM_COMP],
  output logic [2*LEVELS+3:0]     code_out
);

  localparam int unsigned SW        = IN_BITS + LEVELS + 1;
  localparam int unsigned CODE_BITS = 2 * LEVELS + 4;

  logic [SW:0]   mid_sum [nvq_pkg::NUM_COMP];
  logic [SW-1:0] half    [nvq_pkg::NUM_COMP];
  logic [SW-1:0] scaled  [nvq_pkg::NUM_COMP];
  logic [nvq_pkg::NUM_COMP-1:0] above;
  logic [nvq_pkg::NUM_COMP-1:0] below;
  logic [nvq_pkg::NUM_COMP-1:0] hit;
  logic [nvq_pkg::NUM_COMP-1:0] pick;
  nvq_pkg::nvq_sector_t         sector;
  logic [SW-1:0] lo_next [nvq_pkg::NUM_COMP];
  logic [SW-1:0] hi_next [nvq_pkg::NUM_COMP];
  logic          flip_next;

  // Box midpoints, held scaled by the norm. Boxes are dyadic, so the halving is exact.
  always_comb begin
    for (int i = 0; i < nvq_pkg::NUM_COMP; i++) begin
      mid_sum[i] = {1'b0, lo_in[i]} + {1'b0, hi_in[i]};
      half[i]    = mid_sum[i][SW:1];
      scaled[i]  = SW'({mag_in[i], {LEVELS{1'b0}}});
      above[i]   = scaled[i] > half[i];
      below[i]   = scaled[i] < half[i];
    end
  end

  // Priority pick of the sub-triangle: z first, then y, then x, else the corner.
  assign hit     = ctl_in.flip ? below : above;
  assign pick[2] = hit[2];
  assign pick[1] = !hit[2] && hit[1];
  assign pick[0] = !hit[2] && !hit[1] && hit[0];

  always_comb begin
    if (pick[2]) begin
      sector = nvq_pkg::SEC_Z;
    end else if (pick[1]) begin
      sector = nvq_pkg::SEC_Y;
    end else if (pick[0]) begin
      sector = nvq_pkg::SEC_X;
    end else begin
      sector = nvq_pkg::SEC_CORNER;
    end
  end

  // Box update for the next level. The picked axis keeps its old bound on one side.
  always_comb begin
    for (int i = 0; i < nvq_pkg::NUM_COMP; i++) begin
      if (ctl_in.flip) begin
        lo_next[i] = pick[i] ? lo_in[i] : half[i];
        hi_next[i] = pick[i] ? half[i]  : hi_in[i];
      end else begin
        lo_next[i] = pick[i] ? half[i]  : lo_in[i];
        hi_next[i] = pick[i] ? hi_in[i] : half[i];
      end
    end
    case (sector)
      nvq_pkg::SEC_CORNER: flip_next = !ctl_in.flip;
      nvq_pkg::SEC_X,
      nvq_pkg::SEC_Y,
      nvq_pkg::SEC_Z:      flip_next = ctl_in.flip;
      default:             flip_next = ctl_in.flip;
    endcase
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out.valid   <= ctl_in.valid;
      ctl_out.flip    <= flip_next;
      ctl_out.is_null <= ctl_in.is_null;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < nvq_pkg::NUM_COMP; i++) begin
        mag_out[i] <= mag_in[i];
        lo_out[i]  <= lo_next[i];
        hi_out[i]  <= hi_next[i];
      end
      code_out <= {code_in[CODE_BITS-3:0], sector};
    end
  end

endmodule

### rtl/core/normal_vector_quantizer.sv
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+-----------------------------
// input   | in        | in_valid / in_stall | comp_x, comp_y, comp_z
// output  | out       | out_valid/out_stall | code
//
// Each transaction passes through the block in order: one front stage for
// magnitudes and the L1 norm, then one chain cell per subdivision level.
// A new transaction is taken every cycle while the output is not stalled.
// The whole chain advances together; in_stall is high exactly when a result
// waits at the output under out_stall. Synchronous reset empties the chain.
`include "normal_vector_quantizer_macros.svh"

module normal_vector_quantizer #(
  parameter int unsigned LEVELS  = 9,
  parameter int unsigned IN_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [IN_BITS-1:0] comp_x,
  input  logic signed [IN_BITS-1:0] comp_y,
  input  logic signed [IN_BITS-1:0] comp_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2*LEVELS+3:0]       code
);

  localparam int unsigned SW        = IN_BITS + LEVELS + 1;
  localparam int unsigned CODE_BITS = 2 * LEVELS + 4;
  localparam logic [CODE_BITS-1:0] NULL_CODE = {4'b1000, {(2 * LEVELS){1'b0}}};

  logic              en;
  nvq_pkg::nvq_ctl_t ctl_chain  [LEVELS+1];
  logic [IN_BITS-1:0] mag_chain [LEVELS+1][nvq_pkg::NUM_COMP];
  logic [SW-1:0]     lo_chain   [LEVELS+1][nvq_pkg::NUM_COMP];
  logic [SW-1:0]     hi_chain   [LEVELS+1][nvq_pkg::NUM_COMP];
  logic [CODE_BITS-1:0] code_chain [LEVELS+1];

  // The chain moves unless a finished result is held back.
  assign out_valid = ctl_chain[LEVELS].valid;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  // Front stage: octant bits, magnitudes, norm.
  nvq_front #(
    .LEVELS  (LEVELS),
    .IN_BITS (IN_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .comp_x   (comp_x),
    .comp_y   (comp_y),
    .comp_z   (comp_z),
    .ctl_out  (ctl_chain[0]),
    .mag_out  (mag_chain[0]),
    .lo_out   (lo_chain[0]),
    .hi_out   (hi_chain[0]),
    .code_out (code_chain[0])
  );

  // One cell per subdivision level.
  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    nvq_cell #(
      .LEVELS  (LEVELS),
      .IN_BITS (IN_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl_chain[k]),
      .mag_in   (mag_chain[k]),
      .lo_in    (lo_chain[k]),
      .hi_in    (hi_chain[k]),
      .code_in  (code_chain[k]),
      .ctl_out  (ctl_chain[k+1]),
      .mag_out  (mag_chain[k+1]),
      .lo_out   (lo_chain[k+1]),
      .hi_out   (hi_chain[k+1]),
      .code_out (code_chain[k+1])
    );
  end

  // A zero vector gives the null code.
  assign code = ctl_chain[LEVELS].is_null ? NULL_CODE : code_chain[LEVELS];

  // Checks on the chain.
  `NVQ_ASSERT_NOW(a_stall_only_when_held, clk, rst, in_stall, out_valid && out_stall)
  `NVQ_ASSERT_NEXT(a_zero_vector_flagged, clk, rst, in_valid && !in_stall && comp_x == '0 && comp_y == '0 && comp_z == '0, ctl_chain[0].is_null && ctl_chain[0].valid)
  `NVQ_ASSERT_NOW(a_null_bit_alone, clk, rst, out_valid && code[CODE_BITS-1], code[CODE_BITS-2:0] == '0)
  `NVQ_ASSERT_NEXT(a_front_starts_unflipped, clk, rst, en, !ctl_chain[0].flip)

endmodule
